// File: src/sine_tone_beep_generator_top_macros.svh
// Assertion macros for the sine tone beep generator checker.
`ifndef SINE_TONE_BEEP_GENERATOR_TOP_MACROS_SVH
`define SINE_TONE_BEEP_GENERATOR_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define STBG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbg same-cycle check failed");

// Check cons in the cycle after ante.
`define STBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbg next-cycle check failed");

`endif

// File: src/stbg_pkg.sv
// Types, constants and the sine sample table of the sine tone beep generator.
package stbg_pkg;

    localparam int TABLE_LEN  = 130;
    localparam int STORED_LEN = 130;
    localparam int IDX_W      = 8;
    localparam int CLK_W      = 28;
    localparam int FREQ_W     = 16;
    localparam int DUR_W      = 16;
    localparam int SAMPLE_W   = 12;
    localparam int CNT_W      = 32;

    localparam int DIVD_W     = 32;
    localparam int DIVS_W     = 25;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 5;

    localparam int MS_PER_S   = 1000;

    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;
    localparam logic [PADDR_W-1:0]  REG_TIMER_CLOCK_ADDR = 2'd0;
    localparam logic [CLK_W-1:0]    CLOCK_RESET          = 28'd42000000;
    localparam logic [SAMPLE_W-1:0] FIRST_SAMPLE         = 12'd621;

    localparam logic [1:0] STAT_TICK      = 2'd0;
    localparam logic [1:0] STAT_ACCEPT    = 2'd1;
    localparam logic [1:0] STAT_BUSY      = 2'd2;
    localparam logic [1:0] STAT_ZERO_FREQ = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [FREQ_W-1:0] tone_freq_hz;
        logic [DUR_W-1:0]  duration_ms;
    } in_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [SAMPLE_W-1:0] dac_value;
        logic                dac_update;
        logic                playing;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_PERIOD,
        ST_DIV_PASSES,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    localparam logic [SAMPLE_W-1:0] SINE_ROM [STORED_LEN] = '{
        12'd621, 12'd633, 12'd645, 12'd657, 12'd669, 12'd680, 12'd692, 12'd704, 12'd715, 12'd726,
        12'd737, 12'd747, 12'd758, 12'd767, 12'd777, 12'd786, 12'd795, 12'd803, 12'd811, 12'd819,
        12'd826, 12'd833, 12'd839, 12'd844, 12'd849, 12'd854, 12'd857, 12'd861, 12'd864, 12'd866,
        12'd867, 12'd868, 12'd869, 12'd869, 12'd868, 12'd867, 12'd865, 12'd862, 12'd859, 12'd856,
        12'd851, 12'd847, 12'd841, 12'd836, 12'd829, 12'd822, 12'd815, 12'd807, 12'd799, 12'd791,
        12'd782, 12'd772, 12'd763, 12'd752, 12'd742, 12'd731, 12'd720, 12'd709, 12'd698, 12'd686,
        12'd675, 12'd663, 12'd651, 12'd639, 12'd627, 12'd615, 12'd602, 12'd590, 12'd578, 12'd567,
        12'd555, 12'd543, 12'd532, 12'd521, 12'd510, 12'd499, 12'd489, 12'd479, 12'd469, 12'd460,
        12'd450, 12'd442, 12'd434, 12'd426, 12'd419, 12'd412, 12'd406, 12'd400, 12'd395, 12'd390,
        12'd386, 12'd382, 12'd379, 12'd376, 12'd375, 12'd373, 12'd373, 12'd372, 12'd373, 12'd374,
        12'd375, 12'd378, 12'd380, 12'd384, 12'd388, 12'd392, 12'd397, 12'd403, 12'd409, 12'd415,
        12'd422, 12'd430, 12'd438, 12'd446, 12'd455, 12'd464, 12'd474, 12'd484, 12'd494, 12'd504,
        12'd515, 12'd526, 12'd538, 12'd549, 12'd561, 12'd573, 12'd584, 12'd596, 12'd609, 12'd621
    };

    // Positions past the stored table fold back by one table length.
    function automatic logic [SAMPLE_W-1:0] sine_sample(input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] wide;
        logic [IDX_W:0] folded;
        wide = {1'b0, pos};
        if (wide >= (IDX_W+1)'(STORED_LEN))
        begin
            folded = wide - (IDX_W+1)'(STORED_LEN);
        end
        else
        begin
            folded = wide;
        end
        return SINE_ROM[folded[IDX_W-1:0]];
    endfunction

endpackage

// File: src/stbg_div.sv
// Restoring divider, one quotient bit per cycle, shared by both request divisions.
module stbg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  stbg_pkg::div_req_t req,
    output stbg_pkg::div_rsp_t rsp
);
    import stbg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0]    dvd_reg, dvd_next;
    logic [DIVS_W-1:0]    dvs_reg, dvs_next;
    logic [DIVS_W-1:0]    rem_reg, rem_next;

    logic [DIVS_W:0]      trial;
    logic [DIVS_W:0]      diff;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // Shift the quotient bit into the dividend register as it empties.
            rem_next = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            dvd_next = {dvd_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

// File: src/stbg_core.sv
// Sequencer, tone state and output register of the sine tone beep generator.
module stbg_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  stbg_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output stbg_pkg::out_t                 out_data,
    input  logic [stbg_pkg::CLK_W-1:0]     timer_clock_hz,
    output stbg_pkg::div_req_t             div_req,
    input  stbg_pkg::div_rsp_t             div_rsp
);
    import stbg_pkg::*;

    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;
    logic [IDX_W-1:0]    sample_index_reg, sample_index_next;
    logic [CNT_W-1:0]    tick_count_reg, tick_count_next;
    logic [CNT_W-1:0]    sample_period_reg, sample_period_next;
    logic [CNT_W-1:0]    passes_left_reg, passes_left_next;
    logic                running_reg, running_next;
    logic [SAMPLE_W-1:0] held_sample_reg, held_sample_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic [DUR_W-1:0]    dur_reg, dur_next;
    logic [CNT_W-1:0]    period_hold_reg, period_hold_next;

    logic                out_free;
    logic                accept;
    logic                start_req;
    logic                update;
    logic [IDX_W:0]      idx_inc;
    logic                wrap;

    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        accept    = in_valid && in_ready;
        start_req = accept && in_data.mode && !running_reg && (in_data.tone_freq_hz != '0);
        idx_inc   = {1'b0, sample_index_reg} + (IDX_W+1)'(1);
        wrap      = ({1'b0, idx_inc[IDX_W-1:0]} >= (IDX_W+1)'(TABLE_LEN));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_req)
                begin
                    state_next = ST_DIV_PERIOD;
                end
            end
            ST_DIV_PERIOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_PASSES;
                end
            end
            ST_DIV_PASSES:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and divider requests.
    always_comb
    begin
        in_ready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIVD_W'(timer_clock_hz);
        div_req.divisor  = {{(DIVS_W-FREQ_W){1'b0}}, in_data.tone_freq_hz} * DIVS_W'(TABLE_LEN);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = out_free;
                div_req.start = start_req;
            end
            ST_DIV_PERIOD:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {{(DIVD_W-FREQ_W){1'b0}}, freq_reg}
                                 * {{(DIVD_W-DUR_W){1'b0}}, dur_reg};
                div_req.divisor  = DIVS_W'(MS_PER_S);
            end
            ST_DIV_PASSES:
            begin
                div_req.start = 1'b0;
            end
            ST_FINISH:
            begin
                div_req.start = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Tone state and result register.
    always_comb
    begin
        sample_index_next  = sample_index_reg;
        tick_count_next    = tick_count_reg;
        sample_period_next = sample_period_reg;
        passes_left_next   = passes_left_reg;
        running_next       = running_reg;
        held_sample_next   = held_sample_reg;
        freq_next          = freq_reg;
        dur_next           = dur_reg;
        period_hold_next   = period_hold_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_data_next      = out_data_reg;
        update             = 1'b0;

        if (accept && !in_data.mode)
        begin
            if (running_reg)
            begin
                if (tick_count_reg >= sample_period_reg)
                begin
                    tick_count_next  = '0;
                    held_sample_next = sine_sample(sample_index_reg);
                    update           = 1'b1;
                    if (wrap)
                    begin
                        sample_index_next = '0;
                        if (passes_left_reg == '0)
                        begin
                            running_next = 1'b0;
                        end
                        else
                        begin
                            passes_left_next = passes_left_reg - CNT_W'(1);
                        end
                    end
                    else
                    begin
                        sample_index_next = idx_inc[IDX_W-1:0];
                    end
                end
                else
                begin
                    tick_count_next = tick_count_reg + CNT_W'(1);
                end
            end
            out_valid_next           = 1'b1;
            out_data_next.status     = STAT_TICK;
            out_data_next.dac_value  = held_sample_next;
            out_data_next.dac_update = update;
            out_data_next.playing    = running_next;
        end
        else if (accept && in_data.mode)
        begin
            if (start_req)
            begin
                // Hold the request until both divisions are done.
                freq_next = in_data.tone_freq_hz;
                dur_next  = in_data.duration_ms;
            end
            else
            begin
                out_valid_next           = 1'b1;
                out_data_next.status     = running_reg ? STAT_BUSY : STAT_ZERO_FREQ;
                out_data_next.dac_value  = held_sample_reg;
                out_data_next.dac_update = 1'b0;
                out_data_next.playing    = running_reg;
            end
        end

        if ((state_reg == ST_DIV_PERIOD) && div_rsp.done)
        begin
            period_hold_next = div_rsp.quotient;
        end

        if ((state_reg == ST_FINISH) && out_free)
        begin
            sample_period_next       = period_hold_reg;
            passes_left_next         = div_rsp.quotient;
            tick_count_next          = '0;
            running_next             = 1'b1;
            out_valid_next           = 1'b1;
            out_data_next.status     = STAT_ACCEPT;
            out_data_next.dac_value  = held_sample_reg;
            out_data_next.dac_update = 1'b0;
            out_data_next.playing    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            sample_index_reg  <= '0;
            tick_count_reg    <= '0;
            sample_period_reg <= '0;
            passes_left_reg   <= '0;
            running_reg       <= 1'b0;
            held_sample_reg   <= FIRST_SAMPLE;
        end
        else
        begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            sample_index_reg  <= sample_index_next;
            tick_count_reg    <= tick_count_next;
            sample_period_reg <= sample_period_next;
            passes_left_reg   <= passes_left_next;
            running_reg       <= running_next;
            held_sample_reg   <= held_sample_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg    <= out_data_next;
        freq_reg        <= freq_next;
        dur_reg         <= dur_next;
        period_hold_reg <= period_hold_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: src/sine_tone_beep_generator_top.sv
// Top level of the sine tone beep generator: APB register, sequencer and divider.
// Each input transaction is a timer tick or a beep request, and each yields one
// result transaction. A tick, a busy rejection and a zero-frequency rejection
// are answered in the next cycle, so ticks stream at one per clock while the
// result side keeps up. An accepted request gets its result only after the
// sample period and the pass count come from two 32-step divisions on one
// shared restoring divider, and the block does not accept input meanwhile.
// The timer clock register sits at byte address 0 and reads back its value;
// write it only while no transaction is in flight.
module sine_tone_beep_generator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  stbg_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output stbg_pkg::out_t                 out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [stbg_pkg::PADDR_W-1:0]   paddr,
    input  logic [stbg_pkg::PDATA_W-1:0]   pwdata,
    output logic [stbg_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import stbg_pkg::*;

    logic [CLK_W-1:0] timer_clock_reg, timer_clock_next;
    logic             reg_write;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    always_comb
    begin
        reg_write        = psel && penable && pwrite && pready
                         && (paddr == REG_TIMER_CLOCK_ADDR);
        timer_clock_next = reg_write ? pwdata[CLK_W-1:0] : timer_clock_reg;
        prdata           = (paddr == REG_TIMER_CLOCK_ADDR) ? PDATA_W'(timer_clock_reg) : '0;
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clock_reg <= CLOCK_RESET;
        end
        else
        begin
            timer_clock_reg <= timer_clock_next;
        end
    end

    stbg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    stbg_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .timer_clock_hz (timer_clock_reg),
        .div_req        (div_req),
        .div_rsp        (div_rsp)
    );

endmodule

// File: src/stbg_chk.sv
// Port-level checker for the sine tone beep generator, bound to the top level.
`include "sine_tone_beep_generator_top_macros.svh"

module stbg_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input stbg_pkg::out_t out_data,
    input logic           pready
);
    import stbg_pkg::*;

    // A new sample only comes from a tick.
    `STBG_ASSERT_SAME(a_update_on_tick, clk, rst_n, out_valid && out_data.dac_update, out_data.status == STAT_TICK)
    // An accepted beep leaves the tone playing.
    `STBG_ASSERT_SAME(a_accept_plays, clk, rst_n, out_valid && (out_data.status == STAT_ACCEPT), out_data.playing)
    // A busy rejection only happens while a tone plays.
    `STBG_ASSERT_SAME(a_busy_plays, clk, rst_n, out_valid && (out_data.status == STAT_BUSY), out_data.playing)
    // Hold a stalled result.
    `STBG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `STBG_ASSERT_SAME(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind sine_tone_beep_generator_top stbg_chk u_stbg_chk (.*);
